>>> hdl/stop_and_wait_arq_link_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stop-and-wait link unit.
// Shared helpers that keep each concurrent assertion on a single line.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_LINK_UNIT_MACROS_SVH
`define STOP_AND_WAIT_ARQ_LINK_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define SWARQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked on every edge, reset included.
`define SWARQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/swarq_pkg.sv
// ----------------------------------------------------------------------------
// swarq_pkg
// Types, codes, defaults and helpers shared by the link unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swarq_pkg;

  // Default sizing of the block.
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_BUFFER_BYTES = 2048;
  localparam int DEF_HEADER_BYTES = 8;

  // Input beat layout.
  localparam int IN_TDATA_W = 96;
  localparam int IN_TUSER_W = 2;
  localparam int EV_W       = 4;

  // Length check width, holds payload plus header and the largest buffer.
  localparam int LEN_W = 17;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_RECV = 2'd2;

  // Result events.
  localparam logic [3:0] EV_ACCEPTED   = 4'd0;
  localparam logic [3:0] EV_REJECTED   = 4'd1;
  localparam logic [3:0] EV_TRANSMIT   = 4'd2;
  localparam logic [3:0] EV_RETRANSMIT = 4'd3;
  localparam logic [3:0] EV_SEND_ACK   = 4'd4;
  localparam logic [3:0] EV_DELIVER    = 4'd5;
  localparam logic [3:0] EV_CONFIRMED  = 4'd6;
  localparam logic [3:0] EV_DROPPED    = 4'd7;
  localparam logic [3:0] EV_IDLE       = 4'd8;

  // Option bits.
  localparam int OPT_SAFE_BIT      = 0;
  localparam int OPT_DELIVERED_BIT = 1;
  localparam logic [15:0] OPT_DELIVERED = 16'h0002;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEND_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] RST_SEND_INTERVAL  = 16'd100;
  localparam logic [15:0] RST_RETRY_INTERVAL = 16'd1000;
  localparam logic [31:0] RST_TIMEOUT_LIMIT  = 32'd60000;

  typedef struct packed {
    logic [15:0] send_interval;
    logic [15:0] retry_interval;
    logic [31:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] elapsed;
    logic [11:0] payload_size;
    logic [15:0] option;
    logic [15:0] number;
    logic [31:0] checksum;
  } item_t;

  // Descriptor as stored in the send queue RAM.
  typedef struct packed {
    logic [31:0] checksum;
    logic [15:0] option;
    logic [15:0] seq;
  } desc_t;

  // Result fields decided by the engine before the status is attached.
  typedef struct packed {
    logic [3:0]  ev;
    logic [15:0] seq;
    logic [15:0] option;
    logic [31:0] checksum;
  } res_t;

  // Saturating 32-bit timer advance.
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic res_t mk_res(input logic [3:0] ev, input logic [15:0] seq,
                                  input logic [15:0] option, input logic [31:0] checksum);
    res_t r;
    r.ev       = ev;
    r.seq      = seq;
    r.option   = option;
    r.checksum = checksum;
    return r;
  endfunction

endpackage

>>> hdl/swarq_queue_ram.sv
// ----------------------------------------------------------------------------
// swarq_queue_ram
// Send queue descriptor memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swarq_queue_ram import swarq_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/swarq_out_fifo.sv
// ----------------------------------------------------------------------------
// swarq_out_fifo
// Four-entry result buffer that takes up to two results in one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swarq_out_fifo import swarq_pkg::*; #(
  parameter int DATA_W = 70
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  logic [DATA_W-1:0] push0_data,
  input  logic [DATA_W-1:0] push1_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] entries [4];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  logic [2:0]        count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_data  = entries[rd_ptr];
  // Room for a full pair of results.
  assign room      = (count <= 3'd2);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= push0_data;
    end
    if (push1) begin
      entries[wr_ptr + 2'd1] <= push1_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, push0} + {1'b0, push1};
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end
  end

endmodule

>>> hdl/swarq_core.sv
// ----------------------------------------------------------------------------
// swarq_core
// Link engine: timers, sequence numbers and queue pointers, with a read of the
// head descriptor in the send queue RAM for every item and a write per accepted send.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swarq_core import swarq_pkg::*; #(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  localparam int AW    = $clog2(QUEUE_DEPTH),
  localparam int FW    = $clog2(QUEUE_DEPTH + 1),
  localparam int RES_W = EV_W + 16 + 16 + 32 + 1 + FW + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             accept,
  input  item_t            item,
  output logic             busy,
  output logic             ram_rd_en,
  output logic [AW-1:0]    ram_rd_addr,
  input  desc_t            ram_rd_data,
  output logic             ram_wr_en,
  output logic [AW-1:0]    ram_wr_addr,
  output desc_t            ram_wr_data,
  output logic             push0,
  output logic             push1,
  output logic [RES_W-1:0] res0_data,
  output logic [RES_W-1:0] res1_data
);

  // Item held for the update cycle.
  logic        stage_vld;
  item_t       item_q;

  // Link state.
  logic [AW-1:0] queue_head, queue_head_next;
  logic [FW-1:0] queue_fill, queue_fill_next;
  logic [15:0]   next_seq, next_seq_next;
  logic [15:0]   last_recv_seq, last_recv_seq_next;
  logic [15:0]   await_seq, await_seq_next;
  logic [31:0]   await_checksum, await_checksum_next;
  logic [15:0]   pace_timer, pace_timer_next;
  logic [31:0]   retry_timer, retry_timer_next;
  logic [31:0]   idle_timer, idle_timer_next;
  logic          link_up, link_up_next;

  // Update cycle intermediates.
  logic [31:0]   idle_sum;
  logic [31:0]   retry_sum;
  logic [AW-1:0] head_inc;
  logic [AW:0]   enq_sum;
  logic [AW-1:0] enq_addr;
  logic [LEN_W-1:0] len_sum;
  logic          reject;
  logic          pace_hold;
  logic [15:0]   seq_use;
  res_t          res_slot [2];
  logic [1:0]    n_res;

  assign busy        = stage_vld;
  // The head descriptor is fetched as the item comes in.
  assign ram_rd_en   = accept;
  assign ram_rd_addr = queue_head;

  // Address arithmetic and checks.
  always_comb begin
    idle_sum  = sat_add32(idle_timer, item_q.elapsed);
    retry_sum = sat_add32(retry_timer, item_q.elapsed);
    head_inc  = (queue_head == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(queue_head + 1'b1);
    enq_sum   = (AW+1)'(queue_head) + (AW+1)'(queue_fill);
    enq_addr  = (enq_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                AW'(enq_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(enq_sum);
    len_sum   = LEN_W'(item_q.payload_size) + LEN_W'(HEADER_BYTES);
    reject    = (len_sum > LEN_W'(BUFFER_BYTES)) || (queue_fill >= FW'(QUEUE_DEPTH));
    seq_use   = (next_seq == 16'd0) ? 16'd1 : next_seq;
  end

  // Item processing: next state, queue write and results.
  always_comb begin
    queue_head_next     = queue_head;
    queue_fill_next     = queue_fill;
    next_seq_next       = next_seq;
    last_recv_seq_next  = last_recv_seq;
    await_seq_next      = await_seq;
    await_checksum_next = await_checksum;
    pace_timer_next     = pace_timer;
    retry_timer_next    = retry_timer;
    idle_timer_next     = idle_timer;
    link_up_next        = link_up;
    ram_wr_en           = 1'b0;
    ram_wr_addr         = enq_addr;
    ram_wr_data.seq      = seq_use;
    ram_wr_data.option   = item_q.option;
    ram_wr_data.checksum = item_q.checksum;
    pace_hold           = 1'b0;
    res_slot[0]         = mk_res(EV_IDLE, 16'd0, 16'd0, 32'd0);
    res_slot[1]         = mk_res(EV_IDLE, 16'd0, 16'd0, 32'd0);
    n_res               = 2'd0;

    if (stage_vld) begin
      unique case (item_q.action)
        ACT_TICK: begin
          // Idle timeout drops the link.
          idle_timer_next = idle_sum;
          if (idle_sum > cfg.timeout_limit) begin
            idle_timer_next    = '0;
            link_up_next       = 1'b0;
            res_slot[n_res[0]] = mk_res(EV_DROPPED, 16'd0, 16'd0, 32'd0);
            n_res              = n_res + 2'd1;
          end
          if (await_seq != 16'd0) begin
            // Waiting for an ack: retry timer may resend the head.
            retry_timer_next = retry_sum;
            if (retry_sum > {16'b0, cfg.retry_interval}) begin
              retry_timer_next = '0;
              if (queue_fill != '0) begin
                res_slot[n_res[0]] = mk_res(EV_RETRANSMIT, ram_rd_data.seq,
                                            ram_rd_data.option, ram_rd_data.checksum);
                n_res              = n_res + 2'd1;
              end else begin
                await_seq_next  = '0;
                idle_timer_next = '0;
              end
            end
          end else begin
            // Pacing delay gates the next transmission.
            if ((cfg.send_interval != 16'd0) && (pace_timer != 16'd0)) begin
              if (item_q.elapsed < pace_timer) begin
                pace_timer_next = pace_timer - item_q.elapsed;
                pace_hold       = 1'b1;
              end else begin
                pace_timer_next = '0;
              end
            end
            if (!pace_hold && (queue_fill != '0)) begin
              res_slot[n_res[0]] = mk_res(EV_TRANSMIT, ram_rd_data.seq,
                                          ram_rd_data.option, ram_rd_data.checksum);
              n_res              = n_res + 2'd1;
              if (ram_rd_data.option[OPT_SAFE_BIT]) begin
                await_seq_next      = ram_rd_data.seq;
                await_checksum_next = ram_rd_data.checksum;
              end else begin
                queue_head_next = head_inc;
                queue_fill_next = FW'(queue_fill - 1'b1);
              end
              pace_timer_next = cfg.send_interval;
            end
          end
        end
        ACT_SEND: begin
          if (reject) begin
            res_slot[n_res[0]] = mk_res(EV_REJECTED, 16'd0, item_q.option, item_q.checksum);
            n_res              = n_res + 2'd1;
          end else begin
            next_seq_next      = seq_use + 16'd1;
            ram_wr_en          = 1'b1;
            queue_fill_next    = FW'(queue_fill + 1'b1);
            res_slot[n_res[0]] = mk_res(EV_ACCEPTED, seq_use, item_q.option, item_q.checksum);
            n_res              = n_res + 2'd1;
          end
        end
        ACT_RECV: begin
          idle_timer_next = '0;
          link_up_next    = 1'b1;
          if (item_q.option[OPT_DELIVERED_BIT]) begin
            // Acknowledgement, taken only while waiting and on a full match.
            if ((await_seq != 16'd0) && (item_q.number == await_seq) &&
                (item_q.checksum == await_checksum)) begin
              await_seq_next   = '0;
              retry_timer_next = '0;
              if (queue_fill != '0) begin
                queue_head_next = head_inc;
                queue_fill_next = FW'(queue_fill - 1'b1);
              end
              res_slot[n_res[0]] = mk_res(EV_CONFIRMED, item_q.number,
                                          item_q.option, item_q.checksum);
              n_res              = n_res + 2'd1;
            end
          end else begin
            if (item_q.option[OPT_SAFE_BIT]) begin
              res_slot[n_res[0]] = mk_res(EV_SEND_ACK, item_q.number,
                                          OPT_DELIVERED, item_q.checksum);
              n_res              = n_res + 2'd1;
            end
            // Duplicate numbers are not delivered again.
            if (item_q.number != last_recv_seq) begin
              last_recv_seq_next = item_q.number;
              res_slot[n_res[0]] = mk_res(EV_DELIVER, item_q.number,
                                          item_q.option, item_q.checksum);
              n_res              = n_res + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Nothing to report gives a single idle result.
    if (n_res == 2'd0) begin
      n_res = 2'd1;
    end
  end

  // Results carry the link status after the item.
  assign push0     = stage_vld;
  assign push1     = stage_vld && (n_res == 2'd2);
  assign res0_data = {(n_res == 2'd1), queue_fill_next, link_up_next, res_slot[0].checksum,
                      res_slot[0].option, res_slot[0].seq, res_slot[0].ev};
  assign res1_data = {1'b1, queue_fill_next, link_up_next, res_slot[1].checksum,
                      res_slot[1].option, res_slot[1].seq, res_slot[1].ev};

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // Control and link state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld      <= 1'b0;
      queue_head     <= '0;
      queue_fill     <= '0;
      next_seq       <= 16'd1;
      last_recv_seq  <= '0;
      await_seq      <= '0;
      await_checksum <= '0;
      pace_timer     <= '0;
      retry_timer    <= '0;
      idle_timer     <= '0;
      link_up        <= 1'b1;
    end else begin
      stage_vld      <= accept;
      queue_head     <= queue_head_next;
      queue_fill     <= queue_fill_next;
      next_seq       <= next_seq_next;
      last_recv_seq  <= last_recv_seq_next;
      await_seq      <= await_seq_next;
      await_checksum <= await_checksum_next;
      pace_timer     <= pace_timer_next;
      retry_timer    <= retry_timer_next;
      idle_timer     <= idle_timer_next;
      link_up        <= link_up_next;
    end
  end

endmodule

>>> hdl/stop_and_wait_arq_link_unit.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_link_unit
// Stop-and-wait link controller with a RAM-backed send queue.
//
//   Channel  Dir  Handshake          Contents
//   s_*      in   s_tvalid/s_tready  item: tuser kind, tdata fields
//   m_*      out  m_tvalid/m_tready  result: tuser event, tdata fields, tlast
//   cfg_*    in   cfg_we             register index and write data
//
// For each item the head descriptor is read from the queue RAM; then the
// link state is updated, a sent descriptor written to the RAM and the
// results stored. A new item is taken only once the engine is free and
// the output buffer has room for two results; a stalled output backs up
// after that. Reset clears control state only; the queue RAM is not
// cleared, and a descriptor is used only after it has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_and_wait_arq_link_unit import swarq_pkg::*; #(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  localparam int FW          = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_TDATA_W = ((65 + FW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input items.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // elapsed[15:0], payload_size[27:16], option[43:28], number[59:44],
  // checksum[91:60], zero[95:92]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // Results.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // seq_number[15:0], packet_option[31:16], packet_checksum[63:32],
  // connected[64], queue_count[64+FW:65], zero above
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // event_res[3:0]
  output logic [EV_W-1:0]        m_tuser,
  output logic                   m_tlast,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int RES_W = EV_W + 16 + 16 + 32 + 1 + FW + 1;

  cfg_t             cfg;
  item_t            item;
  logic             accept;
  logic             busy;
  logic             room;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  desc_t            ram_rd_data;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  desc_t            ram_wr_data;
  logic             push0;
  logic             push1;
  logic [RES_W-1:0] res0_data;
  logic [RES_W-1:0] res1_data;
  logic [RES_W-1:0] out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_interval  <= RST_SEND_INTERVAL;
      cfg.retry_interval <= RST_RETRY_INTERVAL;
      cfg.timeout_limit  <= RST_TIMEOUT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEND_INTERVAL:  cfg.send_interval  <= cfg_data[15:0];
        REG_RETRY_INTERVAL: cfg.retry_interval <= cfg_data[15:0];
        REG_TIMEOUT_LIMIT:  cfg.timeout_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input beat unpacking.
  assign item.action       = s_tuser[1:0];
  assign item.elapsed      = s_tdata[15:0];
  assign item.payload_size = s_tdata[27:16];
  assign item.option       = s_tdata[43:28];
  assign item.number       = s_tdata[59:44];
  assign item.checksum     = s_tdata[91:60];

  // Take a beat when the engine is free and results have somewhere to go.
  assign s_tready = !busy && room;
  assign accept   = s_tvalid && s_tready;

  swarq_queue_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(desc_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  swarq_core #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .item        (item),
    .busy        (busy),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .push0       (push0),
    .push1       (push1),
    .res0_data   (res0_data),
    .res1_data   (res1_data)
  );

  swarq_out_fifo #(
    .DATA_W (RES_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .push1      (push1),
    .push0_data (res0_data),
    .push1_data (res1_data),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  // Output beat packing.
  assign m_tuser = out_data[EV_W-1:0];
  assign m_tdata = OUT_TDATA_W'(out_data[RES_W-2:EV_W]);
  assign m_tlast = out_data[RES_W-1];

endmodule

>>> hdl/swarq_checker.sv
// ----------------------------------------------------------------------------
// swarq_checker
// Port-level checks on the link unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stop_and_wait_arq_link_unit_macros.svh"

module swarq_checker import swarq_pkg::*; #(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  localparam int FW          = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_TDATA_W = ((65 + FW + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [EV_W-1:0]        m_tuser
);

  // A stalled result beat holds.
  `SWARQ_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // An accepted item leaves the engine busy, so items are never taken back to back.
  `SWARQ_ASSERT(a_in_gap, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken in back-to-back cycles")

  // Every accepted item leads to a result beat on the output.
  `SWARQ_ASSERT(a_in_result, clk, rst, s_tvalid && s_tready |-> ##2 m_tvalid, "no result after an accepted item")

  // The reported queue fill never exceeds the queue depth.
  `SWARQ_ASSERT(a_fill_range, clk, rst, m_tvalid |-> m_tdata[64+FW:65] <= QUEUE_DEPTH, "queue count beyond depth")

  // Reset empties the result buffer.
  `SWARQ_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result pending after reset")

endmodule

bind stop_and_wait_arq_link_unit swarq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_swarq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> bench/stop_and_wait_arq_link_unit_tb.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_link_unit_tb
// Self-checking bench for the stop-and-wait link unit. A behavioral copy of
// the link state predicts every result beat of each accepted item. A checker
// compares all result beats in order, field by field. Directed items cover
// the corner cases, such as the queue-full rejection, pacing and retry
// boundaries, stale acks and a long output stall. Random traffic then runs
// under several register settings, mostly with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_and_wait_arq_link_unit_tb;
  import swarq_pkg::*;

  localparam int OUT_W = 72;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  // One result beat as seen on the output stream.
  typedef struct packed {
    logic [3:0]  ev;
    logic [15:0] seq;
    logic [15:0] opt;
    logic [31:0] ck;
    logic        conn;
    logic [4:0]  count;
    logic        is_last;
  } link_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // elapsed[15:0], payload_size[27:16], option[43:28], number[59:44],
  // checksum[91:60], zero[95:92]
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  // action[1:0]
  logic [IN_TUSER_W-1:0] s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // seq_number[15:0], packet_option[31:16], packet_checksum[63:32],
  // connected[64], queue_count[69:65], zero[71:70]
  logic [OUT_W-1:0]      m_tdata;
  // event_res[3:0]
  logic [EV_W-1:0]       m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  stop_and_wait_arq_link_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted link state.
  desc_t       txq_mem [DEF_QUEUE_DEPTH];
  logic [3:0]  txq_head;
  logic [4:0]  txq_fill;
  logic [15:0] seq_next;
  logic [15:0] rx_last;
  logic [15:0] wait_seq;
  logic [31:0] wait_ck;
  logic [16:0] pace_left;
  logic [31:0] retry_age;
  logic [31:0] idle_age;
  logic        link_ok;
  logic [15:0] p_send_int;
  logic [15:0] p_retry_int;
  logic [31:0] p_timeout;

  // Result beats still owed by the block, oldest first.
  link_event_t events_due[$];

  // Bookkeeping.
  int mismatches = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int reg_writes = 0;
  int ev_seen [16];
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  int hold_req = 0;

  function automatic link_event_t event_of(input logic [3:0] ev, input logic [15:0] seq,
                                           input logic [15:0] opt, input logic [31:0] ck);
    link_event_t e;
    e = '0;
    e.ev  = ev;
    e.seq = seq;
    e.opt = opt;
    e.ck  = ck;
    return e;
  endfunction

  function automatic void reset_link_state();
    txq_head    = '0;
    txq_fill    = '0;
    seq_next    = 16'd1;
    rx_last     = '0;
    wait_seq    = '0;
    wait_ck     = '0;
    pace_left   = '0;
    retry_age   = '0;
    idle_age    = '0;
    link_ok     = 1'b1;
    p_send_int  = RST_SEND_INTERVAL;
    p_retry_int = RST_RETRY_INTERVAL;
    p_timeout   = RST_TIMEOUT_LIMIT;
  endfunction

  // Work out the result beats of one accepted item and queue them.
  function automatic void predict_link_events(input item_t it);
    link_event_t evs [2];
    int          n;
    desc_t       d;
    logic [32:0] sum;
    logic [3:0]  slot;
    logic [15:0] seq;
    logic        go;
    n = 0;
    case (it.action)
      ACT_TICK: begin
        sum = {1'b0, idle_age} + {17'b0, it.elapsed};
        idle_age = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (idle_age > p_timeout) begin
          idle_age = '0;
          link_ok = 1'b0;
          evs[n] = event_of(EV_DROPPED, '0, '0, '0);
          n++;
        end
        if (wait_seq != 0) begin
          // Waiting for an ack: only the retry timer matters.
          sum = {1'b0, retry_age} + {17'b0, it.elapsed};
          retry_age = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (retry_age > {16'b0, p_retry_int}) begin
            retry_age = '0;
            if (txq_fill != 0) begin
              d = txq_mem[txq_head];
              evs[n] = event_of(EV_RETRANSMIT, d.seq, d.option, d.checksum);
              n++;
            end else begin
              wait_seq = '0;
              idle_age = '0;
            end
          end
        end else begin
          go = 1'b1;
          if (p_send_int != 0 && pace_left != 0) begin
            if ({1'b0, it.elapsed} < pace_left) begin
              pace_left = pace_left - {1'b0, it.elapsed};
              go = 1'b0;
            end else begin
              pace_left = '0;
            end
          end
          if (go && txq_fill != 0) begin
            d = txq_mem[txq_head];
            evs[n] = event_of(EV_TRANSMIT, d.seq, d.option, d.checksum);
            n++;
            if (d.option[OPT_SAFE_BIT]) begin
              wait_seq = d.seq;
              wait_ck  = d.checksum;
            end else begin
              txq_head = txq_head + 4'd1;
              txq_fill = txq_fill - 5'd1;
            end
            pace_left = {1'b0, p_send_int};
          end
        end
      end
      ACT_SEND: begin
        if (int'(it.payload_size) + DEF_HEADER_BYTES > DEF_BUFFER_BYTES ||
            txq_fill >= DEF_QUEUE_DEPTH) begin
          evs[n] = event_of(EV_REJECTED, '0, it.option, it.checksum);
          n++;
        end else begin
          // Sequence numbers never take the value zero.
          if (seq_next == 0) seq_next = 16'd1;
          seq = seq_next;
          seq_next = seq_next + 16'd1;
          slot = txq_head + txq_fill[3:0];
          txq_mem[slot].seq      = seq;
          txq_mem[slot].option   = it.option;
          txq_mem[slot].checksum = it.checksum;
          txq_fill = txq_fill + 5'd1;
          evs[n] = event_of(EV_ACCEPTED, seq, it.option, it.checksum);
          n++;
        end
      end
      ACT_RECV: begin
        idle_age = '0;
        link_ok  = 1'b1;
        if (it.option[OPT_DELIVERED_BIT]) begin
          if (wait_seq != 0 && it.number == wait_seq && it.checksum == wait_ck) begin
            wait_seq  = '0;
            retry_age = '0;
            if (txq_fill != 0) begin
              txq_head = txq_head + 4'd1;
              txq_fill = txq_fill - 5'd1;
            end
            evs[n] = event_of(EV_CONFIRMED, it.number, it.option, it.checksum);
            n++;
          end
        end else begin
          if (it.option[OPT_SAFE_BIT]) begin
            evs[n] = event_of(EV_SEND_ACK, it.number, OPT_DELIVERED, it.checksum);
            n++;
          end
          // A repeated number is not delivered again; a safe one is still acknowledged.
          if (it.number != rx_last) begin
            rx_last = it.number;
            evs[n] = event_of(EV_DELIVER, it.number, it.option, it.checksum);
            n++;
          end
        end
      end
      default: begin
      end
    endcase
    if (n == 0) begin
      evs[n] = event_of(EV_IDLE, '0, '0, '0);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      evs[k].conn    = link_ok;
      evs[k].count   = txq_fill;
      evs[k].is_last = (k == n - 1);
      events_due.insert(events_due.size(), evs[k]);
    end
  endfunction

  // Item builders; fields the action does not use carry random bits.
  function automatic item_t noise_item();
    item_t it;
    it.action       = ACT_UNUSED;
    it.elapsed      = 16'($urandom);
    it.payload_size = 12'($urandom);
    it.option       = 16'($urandom);
    it.number       = 16'($urandom);
    it.checksum     = $urandom;
    return it;
  endfunction

  function automatic item_t mk_tick(input logic [15:0] elapsed);
    item_t it;
    it = noise_item();
    it.action  = ACT_TICK;
    it.elapsed = elapsed;
    return it;
  endfunction

  function automatic item_t mk_send(input logic [11:0] size, input logic [15:0] opt,
                                    input logic [31:0] ck);
    item_t it;
    it = noise_item();
    it.action       = ACT_SEND;
    it.payload_size = size;
    it.option       = opt;
    it.checksum     = ck;
    return it;
  endfunction

  function automatic item_t mk_recv(input logic [15:0] opt, input logic [15:0] num,
                                    input logic [31:0] ck);
    item_t it;
    it = noise_item();
    it.action   = ACT_RECV;
    it.option   = opt;
    it.number   = num;
    it.checksum = ck;
    return it;
  endfunction

  // Random traffic biased toward sequences that make progress.
  function automatic item_t random_item();
    item_t it;
    int    r;
    int    r2;
    it = noise_item();
    r  = $urandom_range(0, 99);
    r2 = $urandom_range(0, 99);
    if (r < 30) begin
      it.action = ACT_SEND;
      it.payload_size = (r2 < 10) ? 12'($urandom_range(2041, 4095)) :
                                    12'($urandom_range(0, 2040));
      it.option[OPT_SAFE_BIT] = 1'($urandom_range(0, 1));
    end else if (r < 62) begin
      it.action = ACT_TICK;
      if (r2 < 40)      it.elapsed = 16'($urandom_range(0, 15));
      else if (r2 < 70) it.elapsed = 16'($urandom_range(0, 300));
      else if (r2 < 90) it.elapsed = 16'($urandom_range(0, 3000));
      else              it.elapsed = 16'($urandom_range(0, 65535));
    end else if (r < 82) begin
      // Acknowledgement: mostly the right one, sometimes off by a field.
      it.action = ACT_RECV;
      it.option[OPT_DELIVERED_BIT] = 1'b1;
      if (wait_seq != 0 && r2 < 80) begin
        it.number   = wait_seq;
        it.checksum = wait_ck;
      end else if (r2 < 90) begin
        it.number = wait_seq;
      end else begin
        it.checksum = wait_ck;
      end
    end else if (r < 97) begin
      it.action = ACT_RECV;
      it.option[OPT_DELIVERED_BIT] = 1'b0;
      if (r2 < 40)      it.number = rx_last;
      else if (r2 < 80) it.number = 16'($urandom_range(0, 7));
    end
    return it;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and wait for its beat; valid stays up for the next one.
  task automatic send_item(input item_t it);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= {4'b0, it.checksum, it.number, it.option, it.payload_size, it.elapsed};
    do @(posedge clk); while (!s_tready);
    predict_link_events(it);
    items_sent++;
  endtask

  // Stop offering and let every owed beat come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_SEND_INTERVAL:  p_send_int  = value[15:0];
      REG_RETRY_INTERVAL: p_retry_int = value[15:0];
      REG_TIMEOUT_LIMIT:  p_timeout   = value;
      default: begin
      end
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [15:0] send_int, input logic [15:0] retry_int,
                                input logic [31:0] limit);
    wait_idle();
    write_reg(REG_SEND_INTERVAL, {16'b0, send_int});
    write_reg(REG_RETRY_INTERVAL, {16'b0, retry_int});
    write_reg(REG_TIMEOUT_LIMIT, limit);
  endtask

  // Empty the send queue: confirm a waiting packet, or tick past any pacing.
  task automatic drain_queue();
    while (wait_seq != 0 || txq_fill != 0) begin
      if (wait_seq != 0) send_item(mk_recv(OPT_DELIVERED, wait_seq, wait_ck));
      else send_item(mk_tick(16'hFFFF));
    end
  endtask

  // Corner cases under the reset register values.
  task automatic test_directed();
    send_item(mk_send(12'd0, 16'h0000, 32'h0000_0000));
    send_item(mk_send(12'd2040, 16'h0001, 32'hFFFF_FFFF));
    send_item(mk_send(12'd2041, 16'h0000, $urandom));
    send_item(mk_send(12'd4095, 16'hFFFF, $urandom));
    // Unpaced first send, then the pacing delay in two steps.
    send_item(mk_tick(16'd0));
    send_item(mk_tick(16'd50));
    send_item(mk_tick(16'd50));
    // Retry fires only once the interval is strictly exceeded.
    send_item(mk_tick(16'd1000));
    send_item(mk_tick(16'd1));
    // Acks with a wrong checksum or number, then the right one, then stale.
    send_item(mk_recv(OPT_DELIVERED, 16'd2, 32'hFFFF_FFFE));
    send_item(mk_recv(OPT_DELIVERED, 16'd3, 32'hFFFF_FFFF));
    send_item(mk_recv(OPT_DELIVERED, 16'd2, 32'hFFFF_FFFF));
    send_item(mk_recv(OPT_DELIVERED, 16'd2, 32'hFFFF_FFFF));
    // Safe headers get an ack; repeated numbers are not delivered twice.
    send_item(mk_recv(16'h0001, 16'd5, $urandom));
    send_item(mk_recv(16'h0001, 16'd5, $urandom));
    send_item(mk_recv(16'h0000, 16'd5, $urandom));
    send_item(mk_recv(16'h0000, 16'hFFFF, $urandom));
    send_item(mk_recv(16'h0000, 16'h0000, $urandom));
    send_item(noise_item());
    // Idle timeout drops the link; any received header brings it back.
    send_item(mk_tick(16'hFFFF));
    send_item(mk_tick(16'd0));
    send_item(mk_recv(16'h0000, 16'h0000, 32'h0));
  endtask

  // Sixteen descriptors fill the queue; the next one is rejected.
  task automatic test_queue_full();
    write_all_regs(16'd0, RST_RETRY_INTERVAL, RST_TIMEOUT_LIMIT);
    repeat (DEF_QUEUE_DEPTH + 1)
      send_item(mk_send(12'($urandom_range(0, 2040)), 16'($urandom & 32'hFFFE), $urandom));
    repeat (DEF_QUEUE_DEPTH + 1) send_item(mk_tick(16'd0));
  endtask

  // Unpaced run of send and tick pairs under the widest limits, then a
  // tick under a timeout limit just under the top value.
  task automatic test_long_run();
    write_all_regs(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
    drain_queue();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (60) begin
      send_item(mk_send(12'($urandom_range(0, 2040)), 16'($urandom & 32'hFFFE), $urandom));
      send_item(mk_tick(16'hFFFF));
    end
    wait_idle();
    write_reg(REG_TIMEOUT_LIMIT, 32'hFFFF_FFFE);
    send_item(mk_tick(16'd0));
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Output held off for a long stretch while items keep coming.
  task automatic test_backpressure();
    write_all_regs(16'd0, 16'd50, 32'd100000);
    tx_gaps_on = 1'b0;
    hold_req = 300;
    repeat (40) send_item(random_item());
    tx_gaps_on = 1'b1;
    drain_queue();
  endtask

  // Random traffic under extreme, reset and random register settings.
  task automatic test_random();
    logic [15:0] send_int;
    logic [15:0] retry_int;
    logic [31:0] limit;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_int = 16'd0; retry_int = 16'd1; limit = 32'hFFFF_FFFF; end
        1: begin send_int = 16'hFFFF; retry_int = 16'hFFFF; limit = 32'd1; end
        2: begin
          send_int  = 16'($urandom_range(0, 20));
          retry_int = 16'($urandom_range(5, 200));
          limit     = $urandom_range(200, 5000);
        end
        3: begin send_int = 16'd0; retry_int = 16'd0; limit = 32'd0; end
        4: begin send_int = 16'($urandom); retry_int = 16'($urandom); limit = $urandom; end
        default: begin
          send_int = RST_SEND_INTERVAL; retry_int = RST_RETRY_INTERVAL;
          limit = RST_TIMEOUT_LIMIT;
        end
      endcase
      write_all_regs(send_int, retry_int, limit);
      // One phase runs without any gaps on either side.
      tx_gaps_on = (ph != 2);
      rx_gaps_on = (ph != 2);
      repeat (250) send_item(random_item());
      drain_queue();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver: random short and long stalls, plus a requested long hold.
  initial begin : sink_pacing
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req = 0;
      end else if (stall == 0 && rx_gaps_on && $urandom_range(0, 99) < 15) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest owed one.
  always @(posedge clk) begin : check_results
    link_event_t got;
    link_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ev      = m_tuser;
      got.seq     = m_tdata[15:0];
      got.opt     = m_tdata[31:16];
      got.ck      = m_tdata[63:32];
      got.conn    = m_tdata[64];
      got.count   = m_tdata[69:65];
      got.is_last = m_tlast;
      beats_seen++;
      ev_seen[got.ev]++;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected beat ev=%0d seq=%h opt=%h ck=%h conn=%b cnt=%0d last=%b",
                   $realtime, got.ev, got.seq, got.opt, got.ck, got.conn, got.count,
                   got.is_last);
      end else begin
        want = events_due.pop_front();
        if (got.ev != want.ev || got.seq != want.seq || got.opt != want.opt ||
            got.ck != want.ck || got.conn != want.conn || got.count != want.count ||
            got.is_last != want.is_last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: expected ev=%0d seq=%h opt=%h ck=%h conn=%b cnt=%0d last=%b",
                     $realtime, want.ev, want.seq, want.opt, want.ck, want.conn,
                     want.count, want.is_last);
            $display("%0t:   actual ev=%0d seq=%h opt=%h ck=%h conn=%b cnt=%0d last=%b",
                     $realtime, got.ev, got.seq, got.opt, got.ck, got.conn, got.count,
                     got.is_last);
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #(64'd30_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int k = 0; k < 16; k++) ev_seen[k] = 0;
    reset_link_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_queue_full();
    test_long_run();
    test_backpressure();
    test_random();

    // Let the last beats out, with a bound.
    s_tvalid <= 1'b0;
    for (int k = 0; k < 20000 && events_due.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    mismatches += events_due.size();

    $display("Run covered %0d items, %0d result beats and %0d register writes.",
             items_sent, beats_seen, reg_writes);
    $display("Beats by kind: %0d transmit, %0d retransmit, %0d confirmed, %0d ack, %0d drop, %0d reject.",
             ev_seen[EV_TRANSMIT], ev_seen[EV_RETRANSMIT], ev_seen[EV_CONFIRMED],
             ev_seen[EV_SEND_ACK], ev_seen[EV_DROPPED], ev_seen[EV_REJECTED]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> stop_and_wait_arq_link_unit.f
+incdir+hdl
hdl/swarq_pkg.sv
hdl/swarq_queue_ram.sv
hdl/swarq_out_fifo.sv
hdl/swarq_core.sv
hdl/stop_and_wait_arq_link_unit.sv
hdl/swarq_checker.sv
bench/stop_and_wait_arq_link_unit_tb.sv
